>>> hdl/multi_stepper_needle_sequencer_defines.svh
// Assertion macros for the needle sequencer
`ifndef MULTI_STEPPER_NEEDLE_SEQUENCER_DEFINES_SVH
`define MULTI_STEPPER_NEEDLE_SEQUENCER_DEFINES_SVH

// property must hold on every clock edge out of reset
`define MSN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define MSN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/msn_pkg.sv
// ----------------------------------------------------------------------------
// msn_pkg
// Shared types, constants and tables of the needle sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package msn_pkg;

  localparam int MOTOR_COUNT   = 48;
  localparam int STEPS_PER_REV = 4096;
  localparam int POS_W         = 12;
  localparam int IDX_W         = 6;
  localparam int NEEDLES_PER_DIGIT = 12;

  localparam logic [1:0] CFG_ACCEL  = 2'd0;
  localparam logic [1:0] CFG_SCALE  = 2'd1;
  localparam logic [1:0] CFG_OFFSET = 2'd2;
  localparam logic [1:0] CFG_TARGET = 2'd3;

  localparam logic [2:0] PHASE_OFF = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_SET
  } state_t;

  typedef struct packed {
    logic [11:0] position;
    logic [11:0] steps_left;
    logic [7:0]  delay_now;
    logic [7:0]  delay_goal;
    logic        turn_ccw;
    logic [2:0]  phase;
    logic [31:0] last_step_time;
    logic [3:0]  coil_pattern;
  } motor_t;

  typedef struct packed {
    logic        tick;     // step/idle processing of the head cell
    logic        plan;     // apply a planned target to the head cell
    logic [31:0] time_us;
    logic [11:0] target;
    logic [7:0]  accel;
    logic [7:0]  scale;
    logic [15:0] offset;
    logic [7:0]  tdelay;
  } cell_ctl_t;

  function automatic logic [3:0] coil_of_phase(input logic [2:0] ph);
    case (ph)
      3'd0:    return 4'b1000;
      3'd1:    return 4'b0100;
      3'd2:    return 4'b0010;
      3'd3:    return 4'b0001;
      default: return 4'b0000;
    endcase
  endfunction

  // angle table, 3 bits per entry packed per digit (0:0 1:90 2:180 3:270 4:225)
  function automatic logic [2:0] angle_code(input logic [3:0] dig, input logic [3:0] k);
    logic [35:0] row;
    begin
      case (dig)
        4'd0:    row = {3'd1, 3'd2, 3'd1, 3'd3, 3'd2, 3'd3, 3'd1, 3'd0, 3'd1, 3'd3, 3'd0, 3'd3};
        4'd1:    row = {3'd1, 3'd1, 3'd1, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4};
        4'd2:    row = {3'd2, 3'd2, 3'd2, 3'd1, 3'd3, 3'd2, 3'd0, 3'd1, 3'd0, 3'd3, 3'd0, 3'd0};
        4'd3:    row = {3'd1, 3'd2, 3'd1, 3'd2, 3'd3, 3'd2, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0};
        4'd4:    row = {3'd1, 3'd1, 3'd1, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd0, 3'd1, 3'd3, 3'd3};
        4'd5:    row = {3'd2, 3'd1, 3'd2, 3'd3, 3'd2, 3'd2, 3'd0, 3'd0, 3'd0, 3'd1, 3'd0, 3'd3};
        4'd6:    row = {3'd2, 3'd1, 3'd2, 3'd3, 3'd2, 3'd2, 3'd0, 3'd1, 3'd1, 3'd3, 3'd0, 3'd3};
        4'd7:    row = {3'd1, 3'd1, 3'd1, 3'd3, 3'd2, 3'd3, 3'd4, 3'd4, 3'd4, 3'd4, 3'd0, 3'd0};
        4'd8:    row = {3'd2, 3'd1, 3'd2, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd0, 3'd1, 3'd0, 3'd3};
        4'd9:    row = {3'd2, 3'd1, 3'd1, 3'd3, 3'd2, 3'd3, 3'd0, 3'd0, 3'd1, 3'd0, 3'd0, 3'd3};
        default: row = '0;
      endcase
      return row[k*3 +: 3];
    end
  endfunction

  function automatic logic [11:0] target_of_code(input logic [2:0] c);
    case (c)
      3'd0:    return 12'd4;     // 0 deg
      3'd1:    return 12'd1028;  // 90 deg: 1024 aligned
      3'd2:    return 12'd2052;  // 180 deg
      3'd3:    return 12'd3076;  // 270 deg
      3'd4:    return 12'd2564;  // 225 deg: 2560 aligned
      default: return 12'd4;
    endcase
  endfunction

endpackage

`default_nettype wire

>>> hdl/msn_cell.sv
// ----------------------------------------------------------------------------
// msn_cell
// One motor slot of the rotating state ring; processes the motor passing in
// when it is the head of the ring, otherwise passes the state on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msn_cell
  import msn_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         shift,
  input  wire         head,
  input  cell_ctl_t   ctl,
  input  motor_t      din,
  output motor_t      dout
);

  motor_t m_r, m_nxt;
  logic [16:0] prod;
  logic [32:0] limit;
  logic [31:0] elapsed;
  logic [8:0]  dsum;
  logic [8:0]  gap;
  logic [11:0] cw, ccw;
  motor_t u;

  always_comb begin
    u = din;
    prod = 17'(din.delay_now) * 17'(ctl.scale);
    limit = 33'(prod) + 33'(ctl.offset);
    elapsed = ctl.time_us - din.last_step_time;
    dsum = 9'(din.delay_now) + 9'(ctl.accel);
    gap = 9'(din.delay_now) - 9'(din.delay_goal);
    cw = ctl.target - din.position;
    ccw = 12'(STEPS_PER_REV - 32'(cw));
    if (head && ctl.tick) begin
      if (din.steps_left == '0) begin
        u.phase = PHASE_OFF;
        u.coil_pattern = 4'b0000;
      end else if (din.last_step_time > ctl.time_us || 33'(elapsed) > limit) begin
        u.steps_left = din.steps_left - 12'd1;
        if (!din.turn_ccw) begin
          u.position = din.position + 12'd1;
          u.phase = {1'b0, din.phase[1:0] + 2'd1};
        end else begin
          u.position = din.position - 12'd1;
          u.phase = {1'b0, din.phase[1:0] + 2'd3};
        end
        if (din.delay_goal > din.delay_now)
          u.delay_now = (dsum > 9'(din.delay_goal)) ? din.delay_goal : dsum[7:0];
        else if (din.delay_goal < din.delay_now)
          u.delay_now = (9'(ctl.accel) >= gap) ? din.delay_goal
                                               : din.delay_now - ctl.accel;
        u.coil_pattern = coil_of_phase(u.phase);
        u.last_step_time = ctl.time_us;
      end
    end else if (head && ctl.plan && ctl.target != din.position) begin
      if (cw < ccw && cw != '0) begin
        u.steps_left = cw;
        u.turn_ccw = 1'b0;
      end else begin
        u.steps_left = ccw;
        u.turn_ccw = 1'b1;
      end
      u.delay_goal = ctl.tdelay;
      u.last_step_time = '0;
    end
    m_nxt = shift ? u : m_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r <= '0;
    end else begin
      m_r <= m_nxt;
    end
  end

  assign dout = m_r;

endmodule

`default_nettype wire

>>> hdl/multi_stepper_needle_sequencer.sv
// ----------------------------------------------------------------------------
// multi_stepper_needle_sequencer
// Wave-drive sequencer for 48 stepper needles built on a ring of motor cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a transaction is taken when start is high and busy is low.
//   in_kind 0 is a time tick (in_time_us), 1 sets hours/minutes.
//   Motor state sits in a ring of 48 cells that rotates one place per cycle
//   while busy; the head cell (cell 47) processes one motor per cycle.
//   A transaction occupies the ring until every motor has passed the head; busy is high meanwhile.
//   A tick emits 48 results, one per cycle, out_strobe marking each, in motor
//   order; each is registered from the head cell as the ring rotates,
//   and out_last_of_frame marks the final one. A set-time transaction emits
//   nothing; an out-of-range value still rotates the ring but leaves state
//   unchanged.
//   No new transaction is taken until every motor has passed the head and
//   the sequencer is back in idle, where the next one is taken.
//   The receiver cannot stall: results must be taken as they appear.
//   Config writes land at once; make them while busy is low.
//   Reset clears all motor state and restores register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "multi_stepper_needle_sequencer_defines.svh"

module multi_stepper_needle_sequencer
  import msn_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire         in_kind,
  input  wire  [31:0] in_time_us,
  input  wire  [6:0]  in_hours,
  input  wire  [6:0]  in_minutes,
  output logic        out_strobe,
  output logic [5:0]  out_motor_index,
  output logic [3:0]  out_coil_bits,
  output logic        out_last_of_frame,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_index,
  input  wire  [15:0] cfg_wdata
);

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [31:0] time_r;
  logic [3:0]  dig_r [4];
  logic        valid_r;
  logic [7:0]  accel_r, scale_r, tdelay_r;
  logic [15:0] offset_r;
  logic        out_strobe_r;
  logic [5:0]  out_idx_r;
  logic [3:0]  out_coil_r;
  logic        out_last_r;

  motor_t    ring [MOTOR_COUNT];
  cell_ctl_t ctl;
  logic      shift;
  logic [1:0] dsel;
  logic [3:0] ksel;
  logic [5:0] cnt_hi;
  logic [14:0] hours_mul, mins_mul;
  logic [3:0]  hours_tens, mins_tens;
  logic [6:0]  hours_units, mins_units;

  // tens by reciprocal multiply (x*205 >> 11), exact for all 7-bit values
  always_comb begin
    hours_mul   = 15'(in_hours) * 15'd205;
    mins_mul    = 15'(in_minutes) * 15'd205;
    hours_tens  = hours_mul[14:11];
    mins_tens   = mins_mul[14:11];
    hours_units = in_hours - 7'(hours_tens) * 7'd10;
    mins_units  = in_minutes - 7'(mins_tens) * 7'd10;
  end

  // digit and needle of the current head
  always_comb begin
    cnt_hi = cnt_r;
    dsel = 2'd0;
    ksel = 4'(cnt_hi);
    if (cnt_hi >= 6'd36) begin
      dsel = 2'd3; ksel = 4'(cnt_hi - 6'd36);
    end else if (cnt_hi >= 6'd24) begin
      dsel = 2'd2; ksel = 4'(cnt_hi - 6'd24);
    end else if (cnt_hi >= 6'd12) begin
      dsel = 2'd1; ksel = 4'(cnt_hi - 6'd12);
    end
  end

  assign shift = (state_r != ST_IDLE);

  always_comb begin
    ctl.tick    = (state_r == ST_TICK);
    ctl.plan    = (state_r == ST_SET) && valid_r;
    ctl.time_us = time_r;
    ctl.target  = target_of_code(angle_code(dig_r[dsel], ksel));
    ctl.accel   = accel_r;
    ctl.scale   = scale_r;
    ctl.offset  = offset_r;
    ctl.tdelay  = tdelay_r;
  end

  // cell 47 is the head: it works on motor cnt as it leaves cell 0 and keeps
  // the result; the ring rotates so motor cnt+1 arrives at cell 0.
  genvar g;
  generate
    for (g = 0; g < MOTOR_COUNT; g++) begin : g_ring
      msn_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .shift (shift),
        .head  (g == MOTOR_COUNT - 1),
        .ctl   (ctl),
        .din   (ring[(g + 1) % MOTOR_COUNT]),
        .dout  (ring[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    busy = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (start) state_nxt = in_kind ? ST_SET : ST_TICK;
      end
      ST_TICK, ST_SET: begin
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(MOTOR_COUNT - 1)) begin
          state_nxt = ST_IDLE;
          cnt_nxt = '0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      accel_r      <= 8'd1;
      scale_r      <= 8'd5;
      offset_r     <= 16'd1500;
      tdelay_r     <= 8'd200;
      out_strobe_r <= 1'b0;
      valid_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_strobe_r <= (state_r == ST_TICK);
      if (cfg_we) begin
        case (cfg_index)
          CFG_ACCEL:  accel_r  <= cfg_wdata[7:0];
          CFG_SCALE:  scale_r  <= cfg_wdata[7:0];
          CFG_OFFSET: offset_r <= cfg_wdata;
          CFG_TARGET: tdelay_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
      if (state_r == ST_IDLE && start) begin
        time_r   <= in_time_us;
        valid_r  <= (in_hours <= 7'd99) && (in_minutes <= 7'd99);
        dig_r[0] <= hours_tens;
        dig_r[1] <= hours_units[3:0];
        dig_r[2] <= mins_tens;
        dig_r[3] <= mins_units[3:0];
      end
    end
  end

  // results: the head cell (cell 47) holds the motor just processed
  always_ff @(posedge clk) begin
    out_idx_r  <= cnt_r;
    out_last_r <= (cnt_r == 6'(MOTOR_COUNT - 1));
    out_coil_r <= 4'b0;
  end

  assign out_strobe        = out_strobe_r;
  assign out_motor_index   = out_idx_r;
  assign out_coil_bits     = ring[MOTOR_COUNT - 1].coil_pattern | out_coil_r;
  assign out_last_of_frame = out_last_r;

  `MSN_ASSERT(a_busy_idle, busy == (state_r != ST_IDLE), "busy mismatch")
  `MSN_ASSERT(a_last_ends, !(out_strobe && out_last_of_frame) || !busy,
    "frame end while busy")
  `MSN_ASSERT(a_last_idx, !(out_strobe && out_last_of_frame) || out_motor_index == 6'd47,
    "last flag on wrong motor")

endmodule

`default_nettype wire
